FILE: sv/hsrc_pkg.sv
package hsrc_pkg;

	localparam int unsigned MAX_RESPONSE_BYTES = 8192;
	localparam int unsigned CNT_W = $clog2(MAX_RESPONSE_BYTES + 1);
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam int unsigned PREFIX_LEN = 7;
	localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{
		8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e
	};

	localparam int unsigned STATUS_LINE_MIN = 12;
	localparam logic [9:0] READY_LOW = 10'd200;
	localparam logic [9:0] READY_HIGH = 10'd299;
	localparam logic [9:0] RETRY_LOW = 10'd502;
	localparam logic [9:0] RETRY_HIGH = 10'd504;

	typedef enum logic [1:0] {
		V_INCOMPLETE = 2'd0,
		V_READY = 2'd1,
		V_RETRY = 2'd2,
		V_REJECT = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       is_digit;
		logic       is_space;
		logic       is_lf;
		logic       is_nul;
		logic [3:0] digit;
	} item_t;

endpackage

FILE: sv/hsrc_front.sv
module hsrc_front
	import hsrc_pkg::*;
(
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	output item_t      item
);

	always_comb begin
		item.data = data_byte;
		item.first = first_byte;
		item.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
		item.is_space = (data_byte == CH_SPACE);
		item.is_lf = (data_byte == CH_LF);
		item.is_nul = (data_byte == CH_NUL);
		item.digit = 4'(data_byte - CH_ZERO);
	end

endmodule

FILE: sv/hsrc_queue.sv
module hsrc_queue
	import hsrc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			if (do_pop) rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			if (do_push && !do_pop) count_q <= QCNT_W'(count_q + 1'b1);
			else if (do_pop && !do_push) count_q <= QCNT_W'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: sv/hsrc_back.sv
module hsrc_back
	import hsrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  item_t      head_item,
	output logic       pop,
	output logic [1:0] verdict,
	output logic [9:0] status_code,
	output logic       result_valid,
	input  logic       result_ready
);

	logic [CNT_W-1:0] byte_count_q;
	logic [23:0]      recent_q;
	logic [CNT_W-1:0] line_end_pos_q;
	logic             line_end_found_q;
	logic             prefix_ok_q;
	logic             twelve_space_q;
	logic             bad_char_q;
	logic [9:0]       code_q;
	verdict_t         held_q;

	logic             out_valid_q;
	verdict_t         verdict_q;
	logic [9:0]       status_q;

	logic [CNT_W-1:0] cnt_b, cnt_n;
	logic [23:0]      recent_b, recent_n;
	logic [CNT_W-1:0] lepos_b, lepos_n;
	logic             lef_b, lef_n;
	logic             pok_b, pok_n;
	logic             b12_b, b12_n;
	logic             bad_b, bad_n;
	logic [9:0]       code_b, code_n;
	verdict_t         held_b, held_n;
	logic             hdr_done;
	logic [9:0]       weighted;
	logic [9:0]       status_n;

	assign pop = head_valid && (!out_valid_q || result_ready);

	always_comb begin
		if (head_item.first) begin
			cnt_b = '0;
			recent_b = '0;
			lepos_b = '0;
			lef_b = 1'b0;
			pok_b = 1'b1;
			b12_b = 1'b0;
			bad_b = 1'b0;
			code_b = '0;
			held_b = V_INCOMPLETE;
		end else begin
			cnt_b = byte_count_q;
			recent_b = recent_q;
			lepos_b = line_end_pos_q;
			lef_b = line_end_found_q;
			pok_b = prefix_ok_q;
			b12_b = twelve_space_q;
			bad_b = bad_char_q;
			code_b = code_q;
			held_b = held_q;
		end

		cnt_n = cnt_b;
		recent_n = recent_b;
		lepos_n = lepos_b;
		lef_n = lef_b;
		pok_n = pok_b;
		b12_n = b12_b;
		bad_n = bad_b;
		code_n = code_b;
		held_n = held_b;
		hdr_done = 1'b0;

		case (cnt_b)
			CNT_W'(9):  weighted = 10'(10'(head_item.digit) * 10'd100);
			CNT_W'(10): weighted = 10'(10'(head_item.digit) * 10'd10);
			default:    weighted = 10'(head_item.digit);
		endcase

		if (held_b == V_INCOMPLETE) begin
			if (cnt_b < CNT_W'(PREFIX_LEN)) begin
				if (head_item.data != PREFIX_TEXT[cnt_b[2:0]]) pok_n = 1'b0;
			end else if (cnt_b == CNT_W'(7)) begin
				if (!head_item.is_digit) pok_n = 1'b0;
			end else if (cnt_b == CNT_W'(8)) begin
				if (!head_item.is_space) pok_n = 1'b0;
			end else if (cnt_b <= CNT_W'(11)) begin
				if (head_item.is_digit) code_n = 10'(code_b + weighted);
				else pok_n = 1'b0;
			end else if (cnt_b == CNT_W'(STATUS_LINE_MIN)) begin
				b12_n = head_item.is_space;
			end

			if (head_item.is_nul) bad_n = 1'b1;
			if (head_item.is_lf) begin
				if (recent_b[7:0] != CH_CR) begin
					bad_n = 1'b1;
				end else if (!lef_b) begin
					lef_n = 1'b1;
					lepos_n = CNT_W'(cnt_b - 1'b1);
				end
				if (recent_b == {CH_CR, CH_LF, CH_CR}) hdr_done = 1'b1;
			end

			recent_n = {recent_b[15:0], head_item.data};
			cnt_n = CNT_W'(cnt_b + 1'b1);

			if (hdr_done) begin
				if (lepos_n < CNT_W'(STATUS_LINE_MIN) || !pok_n || bad_n
					|| (lepos_n > CNT_W'(STATUS_LINE_MIN) && !b12_n)) begin
					held_n = V_REJECT;
				end else if (code_n inside {[READY_LOW:READY_HIGH]}) begin
					held_n = V_READY;
				end else if (code_n inside {[RETRY_LOW:RETRY_HIGH]}) begin
					held_n = V_RETRY;
				end else begin
					held_n = V_REJECT;
				end
			end else if (cnt_n >= CNT_W'(MAX_RESPONSE_BYTES)) begin
				held_n = V_REJECT;
			end
		end

		status_n = (pok_n && cnt_n >= CNT_W'(STATUS_LINE_MIN)) ? code_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			recent_q <= '0;
			line_end_pos_q <= '0;
			line_end_found_q <= 1'b0;
			prefix_ok_q <= 1'b1;
			twelve_space_q <= 1'b0;
			bad_char_q <= 1'b0;
			code_q <= '0;
			held_q <= V_INCOMPLETE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				byte_count_q <= cnt_n;
				recent_q <= recent_n;
				line_end_pos_q <= lepos_n;
				line_end_found_q <= lef_n;
				prefix_ok_q <= pok_n;
				twelve_space_q <= b12_n;
				bad_char_q <= bad_n;
				code_q <= code_n;
				held_q <= held_n;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= held_n;
			status_q <= status_n;
		end
	end

	assign result_valid = out_valid_q;
	assign verdict = verdict_q;
	assign status_code = status_q;

endmodule

FILE: sv/http_status_response_classifier_top.sv
// channel   valid          ready          payload
// byte      byte_valid     byte_ready     data_byte[7:0], first_byte
// result    result_valid   result_ready   verdict[1:0], status_code[9:0]
//
// One byte per cycle while not full; a result is registered when its byte is popped.
// The back end updates its running flags as each byte is popped from the queue.
// A four-entry queue lets the byte side keep accepting while results are stalled.
// arst_n clears the queue, the parser state and result_valid; no clearing pass.
module http_status_response_classifier_top
	import hsrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       byte_valid,
	output logic       byte_ready,
	output logic [1:0] verdict,
	output logic [9:0] status_code,
	output logic       result_valid,
	input  logic       result_ready
);

	item_t front_item;
	item_t head_item;
	logic  full;
	logic  head_valid;
	logic  pop;

	hsrc_front u_front (
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.item       (front_item)
	);

	hsrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (byte_valid),
		.push_item  (front_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	hsrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.verdict      (verdict),
		.status_code  (status_code),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	assign byte_ready = !full;

endmodule

FILE: sv/hsrc_checker.sv
module hsrc_checker
	import hsrc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic [1:0] verdict,
	input logic [9:0] status_code,
	input logic       result_valid,
	input logic       result_ready
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(verdict) && $stable(status_code))
		else $error("result changed while stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status_code <= 10'd999)
		else $error("status code out of range");

	a_ready_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && verdict == V_READY |->
			status_code >= READY_LOW && status_code <= READY_HIGH)
		else $error("ready verdict without a success code");

	a_retry_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && verdict == V_RETRY |->
			status_code >= RETRY_LOW && status_code <= RETRY_HIGH)
		else $error("retry verdict without a gateway code");

endmodule

bind http_status_response_classifier_top hsrc_checker u_hsrc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.verdict      (verdict),
	.status_code  (status_code),
	.result_valid (result_valid),
	.result_ready (result_ready)
);
